// ===== hdl/psr_pkg.sv =====
// Shared types and constants of the per-source packet resequencer.
`timescale 1ns / 1ps
`default_nettype none
package psr_pkg;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOKUP,
		S_ARRIVE,
		S_SINGLE,
		S_REL_CHK,
		S_REL_EMIT,
		S_ARM_SCAN,
		S_ARM_CALC,
		S_TICK,
		S_EXP_SCAN,
		S_EXP_EMIT,
		S_EXP_END,
		S_FINISH
	} state_t;

	// Result status codes
	localparam logic [1:0] ST_DELIVERED = 2'd0;
	localparam logic [1:0] ST_BEYOND    = 2'd1;
	localparam logic [1:0] ST_NO_CTX    = 2'd2;
	localparam logic [1:0] ST_DUP_STALE = 2'd3;

	// Input commands
	localparam logic CMD_ARRIVAL = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RTT_MULT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIM  = 2'd2;
	localparam int CFG_DATA_W = 24;

	localparam int TMR_W  = 25;
	localparam int IDLE_W = 24;
	localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

	// One result before it reaches the output register
	typedef struct packed {
		logic [31:0] src;
		logic [31:0] seq;
		logic [31:0] handle;
		logic [1:0]  status;
	} res_t;

	// Buffered slot payload
	typedef struct packed {
		logic [15:0] rtt;
		logic [31:0] handle;
	} slot_t;

endpackage
`default_nettype wire

// ===== hdl/psr_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface psr_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] source_key;
	logic [31:0] seq;
	logic [31:0] cum_seq;
	logic [15:0] rtt_ms;
	logic [31:0] payload_handle;
	modport source (output valid, cmd, source_key, seq, cum_seq, rtt_ms, payload_handle,
		input ready);
	modport sink (input valid, cmd, source_key, seq, cum_seq, rtt_ms, payload_handle,
		output ready);
endinterface

interface psr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_source;
	logic [31:0] out_seq;
	logic [31:0] out_handle;
	logic [1:0]  status;
	logic        last;
	modport source (output valid, out_source, out_seq, out_handle, status, last,
		input ready);
	modport sink (input valid, out_source, out_seq, out_handle, status, last,
		output ready);
endinterface

interface psr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  idx;
	logic [23:0] data;
	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/per_source_packet_resequencer.sv =====
// Per-source packet resequencer top level: context table, window store and sequencer.
//
// Channels: in_ch takes packet arrivals (cmd 0) and one-millisecond ticks (cmd 1);
// out_ch gives released and flagged packets, last marking an item's final result;
// cfg writes gap_base_ticks (0), gap_rtt_mult (1) and idle_limit_ticks (2), always ready.
// Items are taken one at a time; in_ch.ready is high only while the sequencer is idle.
// An arrival passes lookup and classification, then releases packets in order; when the
// timer is left disarmed it adds a slot scan (one slot per cycle, then the timeout
// load). A tick visits each context in turn and, for each expiring context, scans its
// window and flushes its buffered packets. The sequencer returns to idle before the
// next transfer. The slot RAM read port and the single slot scan counter make these
// steps run one slot at a time. One result is held back until the next is known,
// so last is exact.
// Reset clears all contexts at once (valid and slot-full bits are flip-flops) and
// restores the register defaults; no clearing pass is needed.
// When out_ch stalls, the sequencer waits at its next result and in_ch stays low.
`timescale 1ns / 1ps
`default_nettype none
module per_source_packet_resequencer
	import psr_pkg::*;
#(
	parameter int NUM_CONTEXTS = 4,
	parameter int WINDOW       = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	psr_in_if.sink    in_ch,
	psr_out_if.source out_ch,
	psr_cfg_if.sink   cfg
);
	localparam int CW    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int CCW   = $clog2(NUM_CONTEXTS + 1);
	localparam int IW    = $clog2(WINDOW);
	localparam int KW    = $clog2(WINDOW + 1);
	localparam int DEPTH = NUM_CONTEXTS * WINDOW;
	localparam int AW    = $clog2(DEPTH);

	// Configuration registers
	logic [15:0]       base_q;
	logic [7:0]        mult_q;
	logic [IDLE_W-1:0] lim_q;

	// Captured item
	logic        cmd_q;
	logic [31:0] key_q, seq_q, cum_q, hnd_q;
	logic [15:0] rtt_q;

	// Context table
	logic [NUM_CONTEXTS-1:0]             valid_q;
	logic [31:0]                         ckey_q [NUM_CONTEXTS];
	logic [31:0]                         ne_q   [NUM_CONTEXTS];
	logic [IW-1:0]                       head_q [NUM_CONTEXTS];
	logic [NUM_CONTEXTS-1:0][WINDOW-1:0] full_q;
	logic [TMR_W-1:0]                    tmr_q  [NUM_CONTEXTS];
	logic [NUM_CONTEXTS-1:0]             armed_q;
	logic [IDLE_W-1:0]                   idle_q [NUM_CONTEXTS];

	// Sequencer working registers
	state_t        state_q, state_d;
	logic [CCW-1:0] cur_q;
	logic          fresh_q;
	logic [1:0]    stat_q;
	logic [KW-1:0] k_q;
	logic [IW-1:0] ph_q;
	logic [IW-1:0] hi_q;
	logic          hit_q;

	// Combinational
	logic [CW-1:0]    cur;
	logic             tick_end;
	logic             in_acc;
	logic             m_hit, f_hit, restart;
	logic [CW-1:0]    m_idx, f_idx;
	logic [NUM_CONTEXTS-1:0] freev;
	logic [31:0]      d;
	logic [IW-1:0]    dph, head_inc, ph_inc;
	logic             a_stale, a_early, a_far, a_dup, a_buf;
	logic             k_end;
	logic             push, can_push, fin_ok, finish, pend_busy;
	res_t             push_res;
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	slot_t            ram_rdata;
	logic [TMR_W-1:0] gap_tmo;
	logic [NUM_CONTEXTS-1:0] any_full;

	// Slot index plus offset, wrapped into the window
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IW+1)'(WINDOW)) begin
			s = s - (IW+1)'(WINDOW);
		end
		return s[IW-1:0];
	endfunction

	assign cur      = cur_q[CW-1:0];
	assign tick_end = (cur_q == CCW'(NUM_CONTEXTS));
	assign in_acc   = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;

	// Context lookup and lowest free context
	always_comb begin
		m_hit = 1'b0;
		m_idx = '0;
		for (int c = NUM_CONTEXTS - 1; c >= 0; c--) begin
			if (valid_q[c] && ckey_q[c] == key_q) begin
				m_hit = 1'b1;
				m_idx = CW'(c);
			end
		end
		restart = m_hit && (cum_q == 32'd0);
		freev   = ~valid_q;
		if (restart) begin
			freev[m_idx] = 1'b1;
		end
		f_hit = 1'b0;
		f_idx = '0;
		for (int c = NUM_CONTEXTS - 1; c >= 0; c--) begin
			if (freev[c]) begin
				f_hit = 1'b1;
				f_idx = CW'(c);
			end
		end
	end

	// Arrival classification against the current context
	always_comb begin
		d        = seq_q - ne_q[cur];
		dph      = wrap_add(head_q[cur], d[IW-1:0]);
		head_inc = wrap_add(head_q[cur], IW'(1));
		ph_inc   = wrap_add(ph_q, IW'(1));
		a_stale  = !fresh_q && (seq_q < ne_q[cur]);
		a_early  = fresh_q && (seq_q < ne_q[cur]);
		a_far    = d >= 32'(WINDOW);
		a_dup    = full_q[cur][dph];
		a_buf    = !a_stale && !a_early && !a_far && !a_dup;
		k_end    = (k_q == KW'(WINDOW));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = (in_ch.cmd == CMD_TICK) ? S_TICK : S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				state_d = ((m_hit && !restart) || f_hit) ? S_ARRIVE : S_SINGLE;
			end
			S_ARRIVE: state_d = a_buf ? S_REL_CHK : S_SINGLE;
			S_SINGLE: begin
				if (can_push) begin
					state_d = S_FINISH;
				end
			end
			S_REL_CHK: begin
				if (full_q[cur][head_q[cur]]) begin
					state_d = S_REL_EMIT;
				end else begin
					state_d = armed_q[cur] ? S_FINISH : S_ARM_SCAN;
				end
			end
			S_REL_EMIT: begin
				if (can_push) begin
					state_d = S_REL_CHK;
				end
			end
			S_ARM_SCAN: begin
				if (k_end) begin
					state_d = S_FINISH;
				end else if (full_q[cur][ph_q]) begin
					state_d = S_ARM_CALC;
				end
			end
			S_ARM_CALC: state_d = S_FINISH;
			S_TICK: begin
				if (tick_end) begin
					state_d = S_FINISH;
				end else if (valid_q[cur] && armed_q[cur] && tmr_q[cur] <= TMR_W'(1)) begin
					state_d = S_EXP_SCAN;
				end
			end
			S_EXP_SCAN: begin
				if (k_end) begin
					state_d = S_EXP_END;
				end else if (full_q[cur][ph_q]) begin
					state_d = S_EXP_EMIT;
				end
			end
			S_EXP_EMIT: begin
				if (can_push) begin
					state_d = S_EXP_SCAN;
				end
			end
			S_EXP_END: state_d = S_TICK;
			S_FINISH: begin
				if (fin_ok) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		push      = 1'b0;
		push_res  = '{src: key_q, seq: seq_q, handle: hnd_q, status: stat_q};
		ram_re    = 1'b0;
		ram_raddr = AW'(cur) * AW'(WINDOW) + AW'(ph_q);
		ram_we    = 1'b0;
		ram_waddr = AW'(cur) * AW'(WINDOW) + AW'(dph);
		finish    = 1'b0;
		in_ch.ready = 1'b0;
		unique case (state_q)
			S_IDLE:   in_ch.ready = 1'b1;
			S_ARRIVE: ram_we = a_buf;
			S_SINGLE: push = 1'b1;
			S_REL_CHK: begin
				ram_re    = full_q[cur][head_q[cur]];
				ram_raddr = AW'(cur) * AW'(WINDOW) + AW'(head_q[cur]);
			end
			S_REL_EMIT: begin
				push     = 1'b1;
				push_res = '{src: ckey_q[cur], seq: ne_q[cur], handle: ram_rdata.handle,
					status: ST_DELIVERED};
			end
			S_ARM_SCAN, S_EXP_SCAN: ram_re = !k_end && full_q[cur][ph_q];
			S_EXP_EMIT: begin
				push     = 1'b1;
				push_res = '{src: ckey_q[cur], seq: ne_q[cur] + 32'(k_q),
					handle: ram_rdata.handle, status: ST_DELIVERED};
			end
			S_FINISH: finish = 1'b1;
			S_LOOKUP, S_ARM_CALC, S_TICK, S_EXP_END: ;
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q  <= 16'd5000;
			mult_q  <= 8'd10;
			lim_q   <= 24'd240000;
			cmd_q   <= CMD_ARRIVAL;
			valid_q <= '0;
			full_q  <= '0;
			armed_q <= '0;
			cur_q   <= '0;
			fresh_q <= 1'b0;
			stat_q  <= ST_DELIVERED;
			k_q     <= '0;
			ph_q    <= '0;
			hi_q    <= '0;
			hit_q   <= 1'b0;
			for (int c = 0; c < NUM_CONTEXTS; c++) begin
				tmr_q[c]  <= '0;
				idle_q[c] <= '0;
				head_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;

			// Configuration writes
			if (cfg.valid) begin
				unique case (cfg.idx)
					CFG_GAP_BASE: base_q <= cfg.data[15:0];
					CFG_RTT_MULT: mult_q <= cfg.data[7:0];
					CFG_IDLE_LIM: lim_q  <= cfg.data[IDLE_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					cmd_q <= in_ch.cmd;
					cur_q <= '0;
				end
				S_LOOKUP: begin
					// Restart drops the old context without output
					if (restart && (f_idx != m_idx)) begin
						valid_q[m_idx] <= 1'b0;
						full_q[m_idx]  <= '0;
						armed_q[m_idx] <= 1'b0;
						tmr_q[m_idx]   <= '0;
						idle_q[m_idx]  <= '0;
					end
					if (m_hit && !restart) begin
						cur_q   <= CCW'(m_idx);
						fresh_q <= 1'b0;
					end else if (f_hit) begin
						cur_q          <= CCW'(f_idx);
						fresh_q        <= 1'b1;
						valid_q[f_idx] <= 1'b1;
						full_q[f_idx]  <= '0;
						armed_q[f_idx] <= 1'b0;
						tmr_q[f_idx]   <= '0;
						idle_q[f_idx]  <= '0;
						head_q[f_idx]  <= '0;
					end else begin
						stat_q <= ST_NO_CTX;
					end
				end
				S_ARRIVE: begin
					if (!a_stale) begin
						idle_q[cur] <= '0;
					end
					priority if (a_stale) begin
						stat_q <= ST_DUP_STALE;
					end else if (a_early) begin
						stat_q <= ST_DELIVERED;
					end else if (a_far) begin
						stat_q <= ST_BEYOND;
					end else if (a_dup) begin
						stat_q <= ST_DUP_STALE;
					end else begin
						stat_q <= ST_DELIVERED;
					end
					if (a_buf) begin
						full_q[cur][dph] <= 1'b1;
					end
				end
				S_REL_CHK: begin
					k_q  <= '0;
					ph_q <= head_q[cur];
				end
				S_REL_EMIT: begin
					if (can_push) begin
						full_q[cur][head_q[cur]] <= 1'b0;
						head_q[cur]  <= head_inc;
						armed_q[cur] <= 1'b0;
						tmr_q[cur]   <= '0;
					end
				end
				S_ARM_SCAN, S_EXP_SCAN: begin
					if (!k_end && !full_q[cur][ph_q]) begin
						k_q  <= k_q + KW'(1);
						ph_q <= ph_inc;
					end
				end
				S_ARM_CALC: begin
					tmr_q[cur]   <= gap_tmo;
					armed_q[cur] <= 1'b1;
				end
				S_TICK: begin
					if (!tick_end) begin
						if (valid_q[cur]) begin
							if (idle_q[cur] != IDLE_MAX) begin
								idle_q[cur] <= idle_q[cur] + IDLE_W'(1);
							end
							if (armed_q[cur] && tmr_q[cur] <= TMR_W'(1)) begin
								armed_q[cur] <= 1'b0;
								tmr_q[cur]   <= '0;
								k_q          <= '0;
								ph_q         <= head_q[cur];
								hit_q        <= 1'b0;
							end else begin
								if (armed_q[cur]) begin
									tmr_q[cur] <= tmr_q[cur] - TMR_W'(1);
								end
								cur_q <= cur_q + CCW'(1);
							end
						end else begin
							cur_q <= cur_q + CCW'(1);
						end
					end
				end
				S_EXP_EMIT: begin
					if (can_push) begin
						full_q[cur][ph_q] <= 1'b0;
						hi_q  <= k_q[IW-1:0];
						hit_q <= 1'b1;
						k_q   <= k_q + KW'(1);
						ph_q  <= ph_inc;
					end
				end
				S_EXP_END: begin
					// Long-idle context is freed once its window is flushed
					if (idle_q[cur] > lim_q) begin
						valid_q[cur] <= 1'b0;
						idle_q[cur]  <= '0;
					end
					cur_q <= cur_q + CCW'(1);
				end
				S_SINGLE, S_FINISH: ;
				default: ;
			endcase
		end
	end

	// Payload state
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= in_ch.source_key;
			seq_q <= in_ch.seq;
			cum_q <= in_ch.cum_seq;
			rtt_q <= in_ch.rtt_ms;
			hnd_q <= in_ch.payload_handle;
		end
		if (state_q == S_LOOKUP && !(m_hit && !restart) && f_hit) begin
			ckey_q[f_idx] <= key_q;
			ne_q[f_idx]   <= cum_q;
		end
		if (state_q == S_REL_EMIT && can_push) begin
			ne_q[cur] <= ne_q[cur] + 32'd1;
		end
		if (state_q == S_EXP_END && hit_q) begin
			ne_q[cur] <= ne_q[cur] + 32'(hi_q) + 32'd1;
		end
	end

	psr_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({rtt_q, hnd_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	psr_gap_calc u_gap (
		.base    (base_q),
		.mult    (mult_q),
		.rtt     (ram_rdata.rtt),
		.timeout (gap_tmo)
	);

	psr_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.finish    (finish),
		.can_push  (can_push),
		.fin_ok    (fin_ok),
		.pend_busy (pend_busy),
		.out_ch    (out_ch)
	);

	always_comb begin
		for (int c = 0; c < NUM_CONTEXTS; c++) begin
			any_full[c] = |full_q[c];
		end
	end

	// Nothing held back while waiting for a new item
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_busy)
		else $error("result still held while idle");

	// An armed timer always covers a buffered packet
	a_armed_full: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q & ~any_full) == '0)
		else $error("gap timer armed with empty window");

	// Free contexts hold no buffered packets
	a_free_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(~valid_q & any_full) == '0)
		else $error("slot full in a free context");

	// A tick item never reaches the arrival path
	a_tick_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_ch.cmd == CMD_TICK |=> state_q == S_TICK && cmd_q == CMD_TICK)
		else $error("tick item took the arrival path");
endmodule
`default_nettype wire

// ===== hdl/psr_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module psr_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/psr_gap_calc.sv =====
// Gap timeout unit: base ticks plus multiplier times rtt.
`timescale 1ns / 1ps
`default_nettype none
module psr_gap_calc
	import psr_pkg::*;
(
	input  wire logic [15:0]      base,
	input  wire logic [7:0]       mult,
	input  wire logic [15:0]      rtt,
	output      logic [TMR_W-1:0] timeout
);
	logic [23:0] prod;

	// 8x16 product fits 24 bits, sum fits the timer
	always_comb begin
		prod    = 24'(mult) * 24'(rtt);
		timeout = TMR_W'(prod) + TMR_W'(base);
	end
endmodule
`default_nettype wire

// ===== hdl/psr_out_buf.sv =====
// Result holding stage and output register; marks the last result of an item.
`timescale 1ns / 1ps
`default_nettype none
module psr_out_buf
	import psr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire res_t  push_res,
	input  wire logic  finish,
	output      logic  can_push,
	output      logic  fin_ok,
	output      logic  pend_busy,
	psr_out_if.source  out_ch
);
	logic pend_v_q;
	res_t pend_q;
	logic out_v_q;
	res_t out_q;
	logic last_q;
	logic out_free;

	// Output register frees when empty or taken this cycle
	always_comb begin
		out_free  = !out_v_q || out_ch.ready;
		can_push  = !pend_v_q || out_free;
		fin_ok    = !pend_v_q || out_free;
		pend_busy = pend_v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push && can_push) begin
				pend_v_q <= 1'b1;
				out_v_q  <= pend_v_q || (out_v_q && !out_ch.ready);
			end else if (finish && pend_v_q && out_free) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload: a held result moves out once the next one is known
	always_ff @(posedge clk) begin
		if (push && can_push) begin
			pend_q <= push_res;
			if (pend_v_q) begin
				out_q  <= pend_q;
				last_q <= 1'b0;
			end
		end else if (finish && pend_v_q && out_free) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.out_source = out_q.src;
	assign out_ch.out_seq    = out_q.seq;
	assign out_ch.out_handle = out_q.handle;
	assign out_ch.status     = out_q.status;
	assign out_ch.last       = last_q;
endmodule
`default_nettype wire
